// ===== rtl/core/stes_pkg.sv =====
// Shared two-ended stack: types and constants common to all files.
// No dependencies.
package stes_pkg;

   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_POP    = 1'b1;
   localparam logic SIDE_LOW  = 1'b0;
   localparam logic SIDE_HIGH = 1'b1;

   typedef struct packed {
      logic load;
      logic exec;
   } stes_cmd_type;

endpackage

// ===== rtl/core/stes_ctrl.sv =====
// Shared two-ended stack: controller state machine.
// Depends on stes_pkg; drives commands into stes_dp.
module stes_ctrl
   import stes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output stes_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = accept ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff == S_EXEC);
   assign rsp_strobe = (state_ff == S_RESP);
   assign cmd.load   = accept;
   assign cmd.exec   = (state_ff == S_EXEC);

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> cmd.exec)
      else $error("accepted item not executed");

   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_strobe)
      else $error("executed item gave no result");

   a_resp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cmd.exec))
      else $error("result without execution");

endmodule

// ===== rtl/core/stes_dp.sv =====
// Shared two-ended stack: datapath with pointers, store and result registers.
// Depends on stes_pkg; commanded by stes_ctrl.
module stes_dp
   import stes_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  stes_cmd_type               cmd,
   input  logic                       req_op,
   input  logic                       req_side,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_popped
);

   localparam int PTR_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

   logic [WORD_W-1:0]   store [DEPTH];

   logic                op_ff;
   logic                side_ff;
   logic [WORD_W-1:0]   value_ff;
   logic [PTR_W-1:0]    low_count_ff;
   logic [PTR_W-1:0]    low_count_in;
   logic [PTR_W-1:0]    high_bottom_ff;
   logic [PTR_W-1:0]    high_bottom_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [WORD_W-1:0]   rd_data_ff;

   logic                full;
   logic                low_empty;
   logic                high_empty;
   logic                wr_en;
   logic [PTR_W-1:0]    ptr;

   assign full       = (low_count_ff == high_bottom_ff);
   assign low_empty  = (low_count_ff == '0);
   assign high_empty = (high_bottom_ff == PTR_TOP);

   always_comb begin
      status_in      = ST_OK;
      low_count_in   = low_count_ff;
      high_bottom_in = high_bottom_ff;
      wr_en          = 1'b0;
      ptr            = low_count_ff;
      if (op_ff == OP_PUSH) begin
         if (full) begin
            status_in = ST_FULL;
         end else if (side_ff == SIDE_LOW) begin
            wr_en        = 1'b1;
            ptr          = low_count_ff;
            low_count_in = low_count_ff + PTR_ONE;
         end else begin
            wr_en          = 1'b1;
            ptr            = high_bottom_ff - PTR_ONE;
            high_bottom_in = high_bottom_ff - PTR_ONE;
         end
      end else if (side_ff == SIDE_LOW) begin
         ptr = low_count_ff - PTR_ONE;
         if (low_empty) begin
            status_in = ST_EMPTY;
         end else begin
            low_count_in = low_count_ff - PTR_ONE;
         end
      end else begin
         ptr = high_bottom_ff;
         if (high_empty) begin
            status_in = ST_EMPTY;
         end else begin
            high_bottom_in = high_bottom_ff + PTR_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         side_ff  <= req_side;
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff   <= '0;
         high_bottom_ff <= PTR_TOP;
      end else if (cmd.exec) begin
         low_count_ff   <= low_count_in;
         high_bottom_ff <= high_bottom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         store[ptr[ADDR_W-1:0]] <= value_ff;
      end
      if (cmd.exec && (op_ff == OP_POP)) begin
         rd_data_ff <= store[ptr[ADDR_W-1:0]];
      end
   end

   assign rsp_status = status_ff;
   assign rsp_popped = ((op_ff == OP_POP) && (status_ff == ST_OK)) ? rd_data_ff : '0;

   a_order: assert property (@(posedge clock) disable iff (reset)
      low_count_ff <= high_bottom_ff)
      else $error("stack tops crossed");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      high_bottom_ff <= PTR_TOP)
      else $error("high pointer beyond store");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (op_ff == OP_PUSH) && full |=>
         $stable(low_count_ff) && $stable(high_bottom_ff))
      else $error("refused push moved a pointer");

endmodule

// ===== rtl/core/shared_two_ended_stack.sv =====
// Shared two-ended stack: top level joining controller and datapath.
// Depends on stes_pkg, stes_ctrl and stes_dp.
//
// Two stacks share one store of DEPTH 32-bit words: the low stack grows
// up from entry 0, the high stack grows down from entry DEPTH-1.
// Request channel: an item (req_op, req_side, req_value) is taken at a
// rising edge with start high and busy low.
// Result channel: rsp_status and rsp_popped are shown for one cycle with
// rsp_strobe high, once the item has been executed;
// the receiver cannot stall the block.
// The item is registered when taken, the next cycle updates the pointers
// and the store and registers the result, and the result is shown the
// cycle after; a new item may be taken in the cycle its predecessor's
// result is shown.
// A push when the tops meet gives status full; a pop on an empty side
// gives status empty and popped 0; neither changes the stacks.
// Reset empties both stacks at once; the store needs no clearing pass.
module shared_two_ended_stack
   import stes_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_op,
   input  logic                       req_side,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_popped
);

   stes_cmd_type cmd;

   stes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   stes_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_op     (req_op),
      .req_side   (req_side),
      .req_value  (req_value),
      .rsp_status (rsp_status),
      .rsp_popped (rsp_popped)
   );

endmodule
